[rtl/core/ccff_pkg.sv]
`default_nettype none

package ccff_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_NORMAL_STIFF = 3'd0;
  localparam logic [2:0] CFG_SHEAR_STIFF  = 3'd1;
  localparam logic [2:0] CFG_FRICTION     = 3'd2;
  localparam logic [2:0] CFG_TIME_STEP    = 3'd3;
  localparam logic [2:0] CFG_RADIUS_SCALE = 3'd4;
  localparam logic [2:0] CFG_PLANAR       = 3'd5;

  localparam int unsigned DIV_NUM_W = 64;
  localparam int unsigned DIV_DEN_W = 33;
  localparam int unsigned DIV_CNT_W = 6;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [20:0] {
    ST_IDLE = 21'h000001,
    ST_D2   = 21'h000002,
    ST_RR   = 21'h000004,
    ST_SQD  = 21'h000008,
    ST_SCL  = 21'h000010,
    ST_FN   = 21'h000020,
    ST_NDIV = 21'h000040,
    ST_NF   = 21'h000080,
    ST_CDM  = 21'h000100,
    ST_CDD  = 21'h000200,
    ST_S    = 21'h000400,
    ST_DN   = 21'h000800,
    ST_T    = 21'h001000,
    ST_F    = 21'h002000,
    ST_FF   = 21'h004000,
    ST_SQF  = 21'h008000,
    ST_CAP  = 21'h010000,
    ST_QM   = 21'h020000,
    ST_QD   = 21'h040000,
    ST_E    = 21'h080000,
    ST_WB   = 21'h100000
  } ccff_state_e;

endpackage

`default_nettype wire

[rtl/core/contact_coulomb_friction_force.sv]
`default_nettype none
// The work is short when the particles are apart, longer on contact and longest
// with slip; radius scaling (not in planar mode) adds a scaling step. A new request
// is taken only in idle, so one item is worked on at a time. The 64-step iterative
// divider (up to nine quotients) and two 32-step square roots do most of the work;
// multiplies use one shared 34x34 multiplier. Reset clears the configuration, the
// control and the output valid; the datapath and the friction store are not cleared.
module contact_coulomb_friction_force #(
  parameter int unsigned PAIR_COUNT = 1024,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // pair_index, offset_x/y/z, relvel_x/y/z, radius_one, radius_two
  input  wire  [263:0] s_axis_tdata,
  // start_new
  input  wire  [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // normal_x/y/z, friction_x/y/z, contact_dx/dy/dz, energy_lost
  output logic [319:0] m_axis_tdata,
  // touching, slipping
  output logic [1:0]   m_axis_tuser,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [2:0]   cfg_index_i,
  input  wire  [31:0]  cfg_data_i
);
  import ccff_pkg::*;

  localparam int unsigned AW = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
  localparam logic signed [67:0] QBIAS   = (68'sd1 <<< FRAC_BITS) - 68'sd1;
  localparam logic signed [67:0] S32_MAX = 68'sd2147483647;
  localparam logic signed [67:0] S32_MIN = -68'sd2147483648;

  function automatic logic signed [67:0] qdiv(input logic signed [67:0] x);
    return (x + (x[67] ? QBIAS : 68'sd0)) >>> FRAC_BITS;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [67:0] x);
    logic [31:0] r;
    if (x > S32_MAX) r = 32'h7fff_ffff;
    else if (x < S32_MIN) r = 32'h8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [33:0] sx34(input logic [31:0] x);
    return $signed({{2{x[31]}}, x});
  endfunction

  function automatic logic signed [67:0] sx68(input logic [31:0] x);
    return $signed({{36{x[31]}}, x});
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // The index wraps modulo the store depth by conditional subtraction.
  function automatic logic [AW-1:0] pair_slot(input logic [9:0] raw);
    logic [26:0] x;
    x = {17'd0, raw};
    for (int k = 9; k >= 0; k--) begin
      if (x >= (27'(PAIR_COUNT) << k)) x = x - (27'(PAIR_COUNT) << k);
    end
    return x[AW-1:0];
  endfunction

  // Configuration.
  logic [31:0] kn_cfg_q, ks_cfg_q, mu_q, dt_q;
  logic        rscale_q, planar_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kn_cfg_q <= '0;
      ks_cfg_q <= '0;
      mu_q     <= '0;
      dt_q     <= '0;
      rscale_q <= 1'b0;
      planar_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NORMAL_STIFF: kn_cfg_q <= cfg_data_i;
        CFG_SHEAR_STIFF:  ks_cfg_q <= cfg_data_i;
        CFG_FRICTION:     mu_q     <= cfg_data_i;
        CFG_TIME_STEP:    dt_q     <= cfg_data_i;
        CFG_RADIUS_SCALE: rscale_q <= cfg_data_i[0];
        CFG_PLANAR:       planar_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Control.
  ccff_state_e state_q, state_d;
  logic        ph_q, ph_d;
  logic [1:0]  ax_q, ax_d;
  logic        accept, wb_fire, step_done, touch_c, slip_c;

  // Datapath registers.
  logic [AW-1:0]      idx_q;
  logic               fresh_q;
  logic [31:0]        dv_q [3];
  logic [31:0]        vel_q [3];
  logic [30:0]        r2_q;
  logic [32:0]        rsum_q;
  logic [63:0]        d2_q;
  logic [31:0]        d_q;
  logic [32:0]        ov_q;
  logic [31:0]        kn_q, ks_q;
  logic [30:0]        fn_q;
  logic [31:0]        n_q [3];
  logic [31:0]        nf_q [3];
  logic [31:0]        cd_q [3];
  logic [31:0]        s_q [3];
  logic [31:0]        t_q [3];
  logic [31:0]        f_q [3];
  logic signed [63:0] dnacc_q;
  logic signed [33:0] dn_q;
  logic [63:0]        fn2_q;
  logic [31:0]        fnorm_q;
  logic [63:0]        cap_q;
  logic [63:0]        dnum_q;
  logic               dneg_q;
  logic signed [65:0] eacc_q;
  logic [31:0]        energy_q;
  logic               touch_q, slip_q;
  logic [63:0]        sq_x_q, sq_r_q, sq_bit_q;

  // Shared multiplier.
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_q;

  // Friction store.
  logic [95:0] fric_mem [PAIR_COUNT];
  logic [95:0] rd_q;
  logic [AW-1:0] rd_addr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  ccff_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign wb_fire       = (state_q == ST_WB) && (!m_axis_tvalid || m_axis_tready);
  assign rd_addr       = pair_slot(s_axis_tdata[9:0]);

  // Square root step.
  logic [63:0] sq_sum, sq_r_next;
  logic        sq_ge;
  assign sq_sum    = sq_r_q + sq_bit_q;
  assign sq_ge     = sq_x_q >= sq_sum;
  assign sq_r_next = sq_ge ? ((sq_r_q >> 1) + sq_bit_q) : (sq_r_q >> 1);

  // Intermediate values formed from the product register.
  logic signed [67:0] prod_q_div, scl_v, fn_v, cap_v;
  logic signed [63:0] dn_sum;
  logic signed [65:0] e_sum;
  logic [65:0]        e_abs, e_sh;
  logic [31:0]        old_f;

  always_comb begin
    prod_q_div = qdiv(prod_q);
    scl_v      = prod_q >>> (FRAC_BITS + 1);
    fn_v       = prod_q >>> FRAC_BITS;
    cap_v      = prod_q >>> FRAC_BITS;
    dn_sum     = dnacc_q + $signed(prod_q[63:0]);
    e_sum      = eacc_q + $signed(prod_q[65:0]);
    e_abs      = e_sum[65] ? (~e_sum + 66'd1) : e_sum;
    e_sh       = e_abs >> FRAC_BITS;
    old_f      = fresh_q ? 32'd0 : rd_q[ax_q*32 +: 32];
    touch_c    = d2_q < prod_q[65:0];
    slip_c     = cap_v[63:0] < {32'd0, fnorm_q};
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_D2: begin
        mul_a = sx34(dv_q[ax_q]);
        mul_b = sx34(dv_q[ax_q]);
      end
      ST_RR: begin
        mul_a = {1'b0, rsum_q};
        mul_b = {1'b0, rsum_q};
      end
      ST_SCL: begin
        mul_a = {2'b0, (ax_q == 2'd0) ? kn_cfg_q : ks_cfg_q};
        mul_b = {1'b0, rsum_q};
      end
      ST_FN: begin
        mul_a = {2'b0, kn_q};
        mul_b = {1'b0, ov_q};
      end
      ST_NF: begin
        mul_a = {3'b0, fn_q};
        mul_b = sx34(n_q[ax_q]);
      end
      ST_CDM: begin
        mul_a = {3'b0, r2_q};
        mul_b = sx34(dv_q[ax_q]);
      end
      ST_S: begin
        mul_a = sx34(vel_q[ax_q]);
        mul_b = {2'b0, dt_q};
      end
      ST_DN: begin
        mul_a = sx34(s_q[ax_q]);
        mul_b = sx34(n_q[ax_q]);
      end
      ST_T: begin
        mul_a = dn_q;
        mul_b = sx34(n_q[ax_q]);
      end
      ST_F: begin
        mul_a = {2'b0, ks_q};
        mul_b = sx34(t_q[ax_q]);
      end
      ST_FF: begin
        mul_a = sx34(f_q[ax_q]);
        mul_b = sx34(f_q[ax_q]);
      end
      ST_CAP: begin
        mul_a = {2'b0, mu_q};
        mul_b = {3'b0, fn_q};
      end
      ST_QM: begin
        mul_a = {2'b0, abs32(f_q[ax_q])};
        mul_b = {2'b0, cap_q[31:0]};
      end
      ST_E: begin
        mul_a = sx34(f_q[ax_q]);
        mul_b = sx34(t_q[ax_q]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Divider requests.
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    case (state_q)
      ST_NDIV: begin
        div_req.start = !ph_q;
        div_req.num   = {32'd0, abs32(dv_q[ax_q])} << FRAC_BITS;
        div_req.den   = {1'b0, d_q};
      end
      ST_CDD: begin
        div_req.start = !ph_q;
        div_req.num   = dnum_q;
        div_req.den   = rsum_q;
      end
      ST_QD: begin
        div_req.start = !ph_q;
        div_req.num   = dnum_q;
        div_req.den   = {1'b0, fnorm_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    case (state_q)
      ST_NDIV, ST_CDD, ST_QD: step_done = div_rsp.done;
      ST_SQD, ST_SQF:         step_done = sq_bit_q[0];
      default:                step_done = 1'b1;
    endcase
  end

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    ax_d    = ax_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_D2;
          ph_d    = 1'b0;
          ax_d    = 2'd0;
        end
      end
      ST_WB: begin
        if (wb_fire) state_d = ST_IDLE;
      end
      default: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else if (step_done) begin
          ph_d = 1'b0;
          case (state_q)
            ST_D2, ST_NDIV, ST_NF, ST_S, ST_DN, ST_T, ST_F, ST_FF, ST_E: begin
              if (ax_q != 2'd2) begin
                ax_d = ax_q + 2'd1;
              end else begin
                ax_d = 2'd0;
                case (state_q)
                  ST_D2:   state_d = ST_RR;
                  ST_NDIV: state_d = ST_NF;
                  ST_NF:   state_d = ST_CDM;
                  ST_S:    state_d = ST_DN;
                  ST_DN:   state_d = ST_T;
                  ST_T:    state_d = ST_F;
                  ST_F:    state_d = ST_FF;
                  ST_FF:   state_d = ST_SQF;
                  default: state_d = ST_WB;
                endcase
              end
            end
            ST_CDM: state_d = ST_CDD;
            ST_QM:  state_d = ST_QD;
            ST_CDD: begin
              state_d = (ax_q != 2'd2) ? ST_CDM : ST_S;
              ax_d    = (ax_q != 2'd2) ? ax_q + 2'd1 : 2'd0;
            end
            ST_QD: begin
              state_d = (ax_q != 2'd2) ? ST_QM : ST_E;
              ax_d    = (ax_q != 2'd2) ? ax_q + 2'd1 : 2'd0;
            end
            ST_SCL: begin
              state_d = (ax_q != 2'd1) ? ST_SCL : ST_FN;
              ax_d    = (ax_q != 2'd1) ? ax_q + 2'd1 : 2'd0;
            end
            ST_RR:  state_d = touch_c ? ST_SQD : ST_WB;
            ST_SQD: state_d = (rscale_q && !planar_q) ? ST_SCL : ST_FN;
            ST_FN:  state_d = ST_NDIV;
            ST_SQF: state_d = ST_CAP;
            ST_CAP: state_d = slip_c ? ST_QM : ST_WB;
            default: state_d = ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= 1'b0;
      ax_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      ax_q    <= ax_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_q    <= rd_addr;
          fresh_q  <= s_axis_tuser[0];
          dv_q[0]  <= s_axis_tdata[41:10];
          dv_q[1]  <= s_axis_tdata[73:42];
          dv_q[2]  <= s_axis_tdata[105:74];
          vel_q[0] <= s_axis_tdata[137:106];
          vel_q[1] <= s_axis_tdata[169:138];
          vel_q[2] <= s_axis_tdata[201:170];
          r2_q     <= s_axis_tdata[263:233];
          rsum_q   <= {2'b0, s_axis_tdata[232:202]} + {2'b0, s_axis_tdata[263:233]};
          d2_q     <= '0;
          dnacc_q  <= '0;
          fn2_q    <= '0;
          eacc_q   <= '0;
          energy_q <= '0;
          slip_q   <= 1'b0;
          touch_q  <= 1'b0;
        end
      end
      ST_D2:  if (ph_q) d2_q <= d2_q + prod_q[63:0];
      ST_RR:  if (ph_q) touch_q <= touch_c;
      ST_SQD, ST_SQF: begin
        if (!ph_q) begin
          sq_x_q   <= (state_q == ST_SQD) ? d2_q : fn2_q;
          sq_r_q   <= '0;
          sq_bit_q <= 64'd1 << 62;
        end else begin
          if (sq_ge) sq_x_q <= sq_x_q - sq_sum;
          sq_r_q   <= sq_r_next;
          sq_bit_q <= sq_bit_q >> 2;
          if (sq_bit_q[0]) begin
            if (state_q == ST_SQD) begin
              d_q  <= sq_r_next[31:0];
              ov_q <= rsum_q - sq_r_next[32:0];
              kn_q <= kn_cfg_q;
              ks_q <= ks_cfg_q;
            end else begin
              fnorm_q <= sq_r_next[31:0];
            end
          end
        end
      end
      ST_SCL: begin
        if (ph_q) begin
          if (ax_q == 2'd0) kn_q <= (|scl_v[67:32]) ? 32'hffff_ffff : scl_v[31:0];
          else              ks_q <= (|scl_v[67:32]) ? 32'hffff_ffff : scl_v[31:0];
        end
      end
      ST_FN:  if (ph_q) fn_q <= (|fn_v[67:31]) ? 31'h7fff_ffff : fn_v[30:0];
      ST_NDIV: begin
        if (ph_q && div_rsp.done) begin
          if (d_q == 32'd0)        n_q[ax_q] <= '0;
          else if (dv_q[ax_q][31]) n_q[ax_q] <= 32'd0 - div_rsp.quot[31:0];
          else                     n_q[ax_q] <= div_rsp.quot[31:0];
        end
      end
      ST_NF: begin
        if (ph_q) nf_q[ax_q] <= 32'd0 - prod_q_div[31:0];
      end
      ST_CDM, ST_QM: begin
        if (ph_q) begin
          dnum_q <= prod_q[67] ? (64'd0 - prod_q[63:0]) : prod_q[63:0];
          dneg_q <= (state_q == ST_CDM) ? prod_q[67] : f_q[ax_q][31];
        end
      end
      ST_CDD: begin
        if (ph_q && div_rsp.done)
          cd_q[ax_q] <= dneg_q ? (32'd0 - div_rsp.quot[31:0]) : div_rsp.quot[31:0];
      end
      ST_QD: begin
        if (ph_q && div_rsp.done)
          f_q[ax_q] <= dneg_q ? (32'd0 - div_rsp.quot[31:0]) : div_rsp.quot[31:0];
      end
      ST_S:   if (ph_q) s_q[ax_q] <= sat32(prod_q_div);
      ST_DN: begin
        if (ph_q) begin
          dnacc_q <= dn_sum;
          if (ax_q == 2'd2) begin
            dn_q <= 34'(qdiv($signed({{4{dn_sum[63]}}, dn_sum})));
          end
        end
      end
      ST_T: begin
        if (ph_q) t_q[ax_q] <= sat32(sx68(s_q[ax_q]) - prod_q_div);
      end
      ST_F: begin
        if (ph_q) f_q[ax_q] <= sat32(sx68(old_f) + prod_q_div);
      end
      ST_FF:  if (ph_q) fn2_q <= fn2_q + prod_q[63:0];
      ST_CAP: begin
        if (ph_q) begin
          cap_q  <= cap_v[63:0];
          slip_q <= slip_c;
        end
      end
      ST_E: begin
        if (ph_q) begin
          eacc_q <= e_sum;
          if (ax_q == 2'd2) energy_q <= (|e_sh[65:32]) ? 32'hffff_ffff : e_sh[31:0];
        end
      end
      default: ;
    endcase
  end

  // Friction store: read on request, written back once per item.
  always_ff @(posedge clk_i) begin
    if (wb_fire) begin
      fric_mem[idx_q] <= touch_q ? {f_q[2], f_q[1], f_q[0]} : 96'd0;
    end
    if (accept) begin
      rd_q <= fric_mem[rd_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (wb_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_fire) begin
      if (touch_q) begin
        m_axis_tdata <= {energy_q, cd_q[2], cd_q[1], cd_q[0], f_q[2], f_q[1], f_q[0],
                         nf_q[2], nf_q[1], nf_q[0]};
        m_axis_tuser <= {slip_q, 1'b1};
      end else begin
        m_axis_tdata <= '0;
        m_axis_tuser <= 2'b00;
      end
    end
  end

  a_slip_needs_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[1] && !m_axis_tuser[0]))
    else $error("slip reported without contact");

  a_energy_only_on_slip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata[319:288] == 32'd0))
    else $error("energy reported without slip");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_sqrt_bit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SQD || state_q == ST_SQF) && ph_q) |-> $onehot(sq_bit_q))
    else $error("square root step lost its position");

endmodule

`default_nettype wire

[rtl/core/ccff_div.sv]
`default_nettype none

module ccff_div (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire ccff_pkg::div_req_t req_i,
  output ccff_pkg::div_rsp_t      rsp_o
);
  import ccff_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   rem_q;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  // One quotient bit per cycle, restoring form.
  assign rem_sh = {rem_q[DIV_DEN_W-1:0], num_q[DIV_NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == {DIV_CNT_W{1'b1}}) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      num_q <= {num_q[DIV_NUM_W-2:0], fits};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider finished without running");

  // A zero divisor gives a meaningless quotient that the caller discards.
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !$past(req_i.start) && (den_q != '0)) |-> (rem_q < {1'b0, den_q}))
    else $error("partial remainder not reduced");

  a_count_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cnt_q == '0))
    else $error("step counter not at zero while idle");

endmodule

`default_nettype wire
